// ===== rtl/core/owsc_pkg.sv =====
// Package: shared types, constants and the CRC-8 byte update for the scratchpad checker.
package owsc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned TempW   = 16;
  localparam int unsigned ResW    = 2;
  localparam int unsigned IndexW  = 4;

  localparam logic [ByteW-1:0]  CrcPoly    = 8'h8C;
  localparam logic [IndexW-1:0] IdleIndex  = 4'd9;
  localparam logic [IndexW-1:0] LastIndex  = 4'd8;
  localparam logic [IndexW-1:0] TempLoIdx  = 4'd0;
  localparam logic [IndexW-1:0] TempHiIdx  = 4'd1;
  localparam logic [IndexW-1:0] ConfigIdx  = 4'd4;
  localparam int unsigned       ResLsb     = 5;

  // resolution codes R1:R0
  localparam logic [ResW-1:0] Res9Bit  = 2'd0;
  localparam logic [ResW-1:0] Res10Bit = 2'd1;
  localparam logic [ResW-1:0] Res11Bit = 2'd2;
  localparam logic [ResW-1:0] Res12Bit = 2'd3;

  // frame end event from the tracker
  typedef struct packed {
    logic             fire;
    logic             crc_ok;
    logic [TempW-1:0] temp_raw;
    logic [ResW-1:0]  res;
  } frame_evt_t;

  // formatted result word
  typedef struct packed {
    logic                    crc_ok;
    logic signed [TempW-1:0] temp_sixteenths;
    logic [ResW-1:0]         resolution_code;
  } result_t;

  // reflected CRC-8, one byte, LSB first
  function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc_in,
                                                   input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    logic             mix;
    c = crc_in;
    for (int k = 0; k < ByteW; k++) begin
      mix = c[0] ^ data[k];
      c   = c >> 1;
      if (mix) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/owsc_ifs.sv =====
// Interfaces: scratchpad byte channel and result channel.
interface owsc_in_if;
  logic                            valid;
  logic                            ready;
  logic [owsc_pkg::ByteW-1:0]      data_byte;
  logic                            frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface owsc_out_if;
  logic                               valid;
  logic                               ready;
  logic                               crc_ok;
  logic signed [owsc_pkg::TempW-1:0]  temp_sixteenths;
  logic [owsc_pkg::ResW-1:0]          resolution_code;

  modport source (output valid, output crc_ok, output temp_sixteenths,
                  output resolution_code, input ready);
  modport sink   (input valid, input crc_ok, input temp_sixteenths,
                  input resolution_code, output ready);
endinterface

// ===== rtl/core/onewire_scratchpad_temp_checker.sv =====
// Top level: scratchpad CRC check and temperature extraction for a 1-Wire sensor frame.
// Data path: a byte is held in the input register; the result word for byte eight is
// then loaded into the output register once that slot is free or being taken.
// Throughput: one byte per cycle while the output slot is free or being taken,
// set by the combinational CRC byte update.
// Reset (synchronous, rst high): input and output registers empty, tracker idle, waiting
// for a frame start byte; CRC and captured bytes cleared.
module onewire_scratchpad_temp_checker (
  input  logic              clk,
  input  logic              rst,
  owsc_in_if.sink           frame_bytes,
  owsc_out_if.source        results
);

  // input register
  logic                        in_valid;
  logic [owsc_pkg::ByteW-1:0]  in_byte;
  logic                        in_start;

  // output register
  logic                        out_valid;
  owsc_pkg::result_t           out_word;

  owsc_pkg::frame_evt_t        evt;
  owsc_pkg::result_t           fmt_word;
  logic                        out_free;
  logic                        step;

  // the output slot is free when empty or being taken this cycle
  assign out_free = !out_valid || results.ready;
  // advance the held byte when its result, if any, has somewhere to go
  assign step = in_valid && out_free;
  // take a new word whenever the input register empties or is empty
  assign frame_bytes.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (frame_bytes.ready) begin
      in_valid <= frame_bytes.valid;
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk) begin
    if (frame_bytes.ready && frame_bytes.valid) begin
      in_byte  <= frame_bytes.data_byte;
      in_start <= frame_bytes.frame_start;
    end
  end

  owsc_frame_track u_track (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .data_byte   (in_byte),
    .frame_start (in_start),
    .evt         (evt)
  );

  owsc_result_fmt u_fmt (
    .evt (evt),
    .res (fmt_word)
  );

  // result register: load on frame end, drop the word once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= evt.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && evt.fire) begin
      out_word <= fmt_word;
    end
  end

  assign results.valid           = out_valid;
  assign results.crc_ok          = out_word.crc_ok;
  assign results.temp_sixteenths = out_word.temp_sixteenths;
  assign results.resolution_code = out_word.resolution_code;

endmodule

// ===== rtl/core/owsc_frame_track.sv =====
// Frame tracker: byte position, running CRC and captured temperature and resolution bytes.
module owsc_frame_track (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [owsc_pkg::ByteW-1:0]   data_byte,
  input  logic                         frame_start,
  output owsc_pkg::frame_evt_t         evt
);

  logic [owsc_pkg::IndexW-1:0] byte_index;
  logic [owsc_pkg::ByteW-1:0]  running_crc;
  logic [owsc_pkg::ByteW-1:0]  temp_low_byte;
  logic [owsc_pkg::ByteW-1:0]  temp_high_byte;
  logic [owsc_pkg::ResW-1:0]   resolution_bits;
  logic [owsc_pkg::ByteW-1:0]  crc_next;
  logic                        in_frame;

  assign in_frame = (byte_index < owsc_pkg::IdleIndex);
  assign crc_next = owsc_pkg::crc8_update(frame_start ? '0 : running_crc, data_byte);

  always_comb begin
    evt.fire     = step && !frame_start && (byte_index == owsc_pkg::LastIndex);
    evt.crc_ok   = (running_crc == data_byte);
    evt.temp_raw = {temp_high_byte, temp_low_byte};
    evt.res      = resolution_bits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index      <= owsc_pkg::IdleIndex;
      running_crc     <= '0;
      temp_low_byte   <= '0;
      temp_high_byte  <= '0;
      resolution_bits <= '0;
    end else if (step) begin
      if (frame_start) begin
        running_crc   <= crc_next;
        temp_low_byte <= data_byte;
        byte_index    <= owsc_pkg::IndexW'(1);
      end else if (in_frame) begin
        if (byte_index == owsc_pkg::LastIndex) begin
          byte_index <= owsc_pkg::IdleIndex;
        end else begin
          running_crc <= crc_next;
          byte_index  <= byte_index + owsc_pkg::IndexW'(1);
          if (byte_index == owsc_pkg::TempLoIdx) begin
            temp_low_byte <= data_byte;
          end else if (byte_index == owsc_pkg::TempHiIdx) begin
            temp_high_byte <= data_byte;
          end else if (byte_index == owsc_pkg::ConfigIdx) begin
            resolution_bits <= data_byte[owsc_pkg::ResLsb +: owsc_pkg::ResW];
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/owsc_result_fmt.sv =====
// Result formatter: resolution masking and zeroing on CRC mismatch.
module owsc_result_fmt (
  input  owsc_pkg::frame_evt_t evt,
  output owsc_pkg::result_t    res
);

  logic [owsc_pkg::TempW-1:0] masked;

  always_comb begin
    case (evt.res)
      owsc_pkg::Res9Bit:  masked = evt.temp_raw & ~owsc_pkg::TempW'(16'h0007);
      owsc_pkg::Res10Bit: masked = evt.temp_raw & ~owsc_pkg::TempW'(16'h0003);
      owsc_pkg::Res11Bit: masked = evt.temp_raw & ~owsc_pkg::TempW'(16'h0001);
      default:            masked = evt.temp_raw;
    endcase
  end

  always_comb begin
    res.crc_ok          = evt.crc_ok;
    res.temp_sixteenths = evt.crc_ok ? $signed(masked) : '0;
    res.resolution_code = evt.crc_ok ? evt.res : '0;
  end

endmodule

// ===== rtl/core/owsc_checker.sv =====
// Checker: port-level assertions on the scratchpad checker, bound to the top level.
module owsc_checker (
  input  logic         clk,
  input  logic         rst,
  owsc_in_if.sink      frame_bytes,
  owsc_out_if.source   results
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |=> results.valid && $stable(results.temp_sixteenths)
      && $stable(results.crc_ok) && $stable(results.resolution_code))
    else $error("result word changed while stalled");

  // a failed check reports zero temperature and zero resolution
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.crc_ok |-> results.temp_sixteenths == 16'sd0
      && results.resolution_code == 2'd0)
    else $error("CRC failure with non-zero payload");

  // unused low bits cleared at reduced resolution
  a_mask: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.crc_ok |->
      (results.resolution_code != 2'd0 || results.temp_sixteenths[2:0] == 3'd0) &&
      (results.resolution_code != 2'd1 || results.temp_sixteenths[1:0] == 2'd0) &&
      (results.resolution_code != 2'd2 || results.temp_sixteenths[0] == 1'b0))
    else $error("resolution mask not applied");

  // no result word in the first cycle after reset
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !results.valid)
    else $error("result word straight out of reset");

endmodule

bind onewire_scratchpad_temp_checker owsc_checker u_owsc_checker (
  .clk         (clk),
  .rst         (rst),
  .frame_bytes (frame_bytes),
  .results     (results)
);

// ===== tb/onewire_scratchpad_temp_checker_tb.sv =====
// Testbench: drives scratchpad frames into the checker and matches every result word.
module onewire_scratchpad_temp_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WordTarget  = 1150; // input words before the stimulus stops
  localparam int unsigned QuietWords  = 120;  // closing stretch with no idling on either side
  localparam int unsigned StallLimit  = 500;  // cycles with nothing accepted before giving up
  localparam int unsigned DrainCycles = 8;    // margin after the last reading to catch strays
  localparam int unsigned FrameLen    = 9;

  // Scoreboard: tracks the frame the way the block should and queues the readings
  // that byte eight must produce.
  class scratchpad_board;
    logic [owsc_pkg::IndexW-1:0] next_index;
    logic [owsc_pkg::ByteW-1:0]  crc_acc;
    logic [owsc_pkg::ByteW-1:0]  temp_lo;
    logic [owsc_pkg::ByteW-1:0]  temp_hi;
    logic [owsc_pkg::ResW-1:0]   res_bits;
    owsc_pkg::result_t           expected_readings[$];
    int unsigned                 mismatches;

    function new();
      next_index = owsc_pkg::IdleIndex;
      crc_acc    = '0;
      temp_lo    = '0;
      temp_hi    = '0;
      res_bits   = '0;
      mismatches = 0;
    endfunction

    // Reflected CRC-8, least significant bit first.
    static function logic [owsc_pkg::ByteW-1:0] crc_byte(
        input logic [owsc_pkg::ByteW-1:0] crc,
        input logic [owsc_pkg::ByteW-1:0] data);
      logic [owsc_pkg::ByteW-1:0] c;
      c = crc;
      for (int k = 0; k < owsc_pkg::ByteW; k++) begin
        c = (c[0] ^ data[k]) ? ((c >> 1) ^ owsc_pkg::CrcPoly) : (c >> 1);
      end
      return c;
    endfunction

    task flag(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    function int unsigned pending();
      return expected_readings.size();
    endfunction

    function void take_byte(input logic [owsc_pkg::ByteW-1:0] data, input logic start);
      logic [owsc_pkg::TempW-1:0] raw;
      owsc_pkg::result_t          reading;
      if (start) begin
        // a start word always opens a fresh frame, whatever was in progress
        crc_acc    = crc_byte('0, data);
        temp_lo    = data;
        next_index = owsc_pkg::TempHiIdx;
      end else if (next_index < owsc_pkg::LastIndex) begin
        crc_acc = crc_byte(crc_acc, data);
        case (next_index)
          owsc_pkg::TempLoIdx: temp_lo  = data;
          owsc_pkg::TempHiIdx: temp_hi  = data;
          owsc_pkg::ConfigIdx: res_bits = data[owsc_pkg::ResLsb +: owsc_pkg::ResW];
          default: ;
        endcase
        next_index = next_index + 1'b1;
      end else if (next_index == owsc_pkg::LastIndex) begin
        next_index = owsc_pkg::IdleIndex;
        raw = {temp_hi, temp_lo};
        case (res_bits)
          owsc_pkg::Res9Bit:  raw[2:0] = '0;
          owsc_pkg::Res10Bit: raw[1:0] = '0;
          owsc_pkg::Res11Bit: raw[0]   = 1'b0;
          default: ;
        endcase
        reading.crc_ok = (crc_acc == data);
        reading.temp_sixteenths = reading.crc_ok ? raw : '0;
        reading.resolution_code = reading.crc_ok ? res_bits : '0;
        expected_readings.push_back(reading);
      end
      // anything else is an idle word and is dropped
    endfunction

    task match_reading(input logic ok, input logic signed [owsc_pkg::TempW-1:0] temp,
                       input logic [owsc_pkg::ResW-1:0] res);
      owsc_pkg::result_t want;
      if (expected_readings.size() == 0) begin
        flag($sformatf("unexpected result crc_ok=%0b temp=%0d res=%0d", ok, temp, res));
        return;
      end
      want = expected_readings.pop_front();
      if (ok !== want.crc_ok)
        flag($sformatf("crc_ok got %0b want %0b", ok, want.crc_ok));
      if (temp !== want.temp_sixteenths)
        flag($sformatf("temp_sixteenths got %0d want %0d", temp, want.temp_sixteenths));
      if (res !== want.resolution_code)
        flag($sformatf("resolution_code got %0d want %0d", res, want.resolution_code));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  owsc_in_if  frame_bytes ();
  owsc_out_if results ();

  onewire_scratchpad_temp_checker i_dut (
    .clk         (clk),
    .rst         (rst),
    .frame_bytes (frame_bytes),
    .results     (results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  scratchpad_board            board;
  logic [owsc_pkg::ByteW-1:0] frame_buf [FrameLen];
  int unsigned                words_sent = 0;
  int unsigned                stall_count = 0;
  bit                         quiet = 1'b0;

  // Offer one word, with an occasional idle burst first, and hold it until taken.
  task automatic send_word(input logic [owsc_pkg::ByteW-1:0] data, input logic start);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 12);
    if (gap != 0) begin
      frame_bytes.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_bytes.valid       <= 1'b1;
    frame_bytes.data_byte   <= data;
    frame_bytes.frame_start <= start;
    @(posedge clk);
    while (!frame_bytes.ready) @(posedge clk);
    board.take_byte(data, start);
    words_sent++;
    // drop all idling for the closing stretch
    if (words_sent + QuietWords >= WordTarget) quiet = 1'b1;
  endtask

  // Fill bytes 0 to 8 with random content; byte 4 thereby carries a random resolution.
  task automatic fill_frame();
    for (int i = 0; i < FrameLen; i++) frame_buf[i] = owsc_pkg::ByteW'($urandom_range(0, 255));
  endtask

  // Work out byte eight from bytes 0 to 7, optionally spoiling it.
  task automatic seal_frame(input logic bad_crc);
    logic [owsc_pkg::ByteW-1:0] crc;
    crc = '0;
    for (int i = 0; i < FrameLen - 1; i++) crc = scratchpad_board::crc_byte(crc, frame_buf[i]);
    frame_buf[FrameLen-1] = bad_crc ? (crc ^ owsc_pkg::ByteW'($urandom_range(1, 255))) : crc;
  endtask

  // Send the first len bytes of the frame buffer, the first one marked as frame start.
  task automatic send_frame(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_word(frame_buf[i], i == 0);
  endtask

  // Result side: accept in bursts, stalling now and then.
  initial begin
    results.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        results.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      results.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // Every accepted result word goes straight to the scoreboard.
  always @(posedge clk) begin
    if (!rst && results.valid && results.ready)
      board.match_reading(results.crc_ok, results.temp_sixteenths, results.resolution_code);
  end

  // Watchdog: abandon the run if neither side moves a word for too long.
  always @(posedge clk) begin
    if (rst || (frame_bytes.valid && frame_bytes.ready) || (results.valid && results.ready)) begin
      stall_count <= 0;
    end else if (stall_count >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin : stimulus
    int unsigned                pick;
    logic [owsc_pkg::TempW-1:0] corner;
    board = new();
    frame_bytes.valid       = 1'b0;
    frame_bytes.data_byte   = '0;
    frame_bytes.frame_start = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // A stray word straight after reset: the tracker is idle, so no result.
    send_word(8'hFF, 1'b0);
    // Partial frame, dropped when the next frame start arrives mid-frame.
    fill_frame();
    seal_frame(1'b0);
    send_frame(4);
    // Good frame, all-ones temperature at 9-bit resolution: low three bits cleared.
    fill_frame();
    frame_buf[owsc_pkg::TempLoIdx] = 8'hFF;
    frame_buf[owsc_pkg::TempHiIdx] = 8'hFF;
    frame_buf[owsc_pkg::ConfigIdx][owsc_pkg::ResLsb +: owsc_pkg::ResW] = owsc_pkg::Res9Bit;
    seal_frame(1'b0);
    send_frame(FrameLen);
    // A word past the ninth is ignored until the next frame start.
    send_word(8'h00, 1'b0);
    // Most negative reading at 12-bit resolution, but with a bad CRC: all fields zero.
    fill_frame();
    frame_buf[owsc_pkg::TempLoIdx] = 8'h00;
    frame_buf[owsc_pkg::TempHiIdx] = 8'h80;
    frame_buf[owsc_pkg::ConfigIdx][owsc_pkg::ResLsb +: owsc_pkg::ResW] = owsc_pkg::Res12Bit;
    seal_frame(1'b1);
    send_frame(FrameLen);

    // Random part: mostly well-formed frames, mixed with bad CRCs, cut-off frames and noise.
    while (words_sent < WordTarget) begin
      pick = $urandom_range(0, 99);
      fill_frame();
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: corner = 16'h0000;
          1: corner = 16'h7FFF;
          2: corner = 16'h8000;
          default: corner = 16'hFFFF;
        endcase
        {frame_buf[owsc_pkg::TempHiIdx], frame_buf[owsc_pkg::TempLoIdx]} = corner;
      end
      if (pick < 70) begin
        seal_frame(1'b0);
        send_frame(FrameLen);
      end else if (pick < 82) begin
        seal_frame(1'b1);
        send_frame(FrameLen);
      end else if (pick < 92) begin
        seal_frame(1'b0);
        send_frame($urandom_range(1, FrameLen - 1));
      end else begin
        repeat ($urandom_range(1, 3))
          send_word(owsc_pkg::ByteW'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
      // now and then a trailing word after the frame
      if ($urandom_range(0, 9) == 0)
        send_word(owsc_pkg::ByteW'($urandom_range(0, 255)), 1'b0);
    end
    frame_bytes.valid <= 1'b0;

    // Drain: wait for every reading, then wait out the drain margin to catch strays.
    while (board.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/owsc_pkg.sv
rtl/core/owsc_ifs.sv
rtl/core/owsc_frame_track.sv
rtl/core/owsc_result_fmt.sv
rtl/core/onewire_scratchpad_temp_checker.sv
rtl/core/owsc_checker.sv
tb/onewire_scratchpad_temp_checker_tb.sv
